// ===== hw/rtl/cia_pkg.sv =====
`default_nettype none
package cia_pkg;

   localparam int DIV_STEPS = 64;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_MUL = 2'd1;
   localparam logic [1:0] FUNC_DIV = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam logic [1:0] WIDTH_8 = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam logic [2:0] ERR_OK = 3'd0;
   localparam logic [2:0] ERR_ADD_OVF = 3'd1;
   localparam logic [2:0] ERR_MUL_OVF = 3'd2;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd3;
   localparam logic [2:0] ERR_DIV_OVF = 3'd4;

   typedef struct packed {
      logic        valid;
      logic [1:0]  func;
      logic [1:0]  wsel;
      logic        sgn;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] divisor;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] mhi;
      logic [63:0] mlo;
   } stage_type;

   function automatic logic [63:0] ext_value(input logic [63:0] x, input logic [1:0] wsel,
                                             input logic sgn);
      logic [63:0] r;
      unique case (wsel)
         WIDTH_8:  r = sgn ? {{56{x[7]}}, x[7:0]} : {56'b0, x[7:0]};
         WIDTH_16: r = sgn ? {{48{x[15]}}, x[15:0]} : {48'b0, x[15:0]};
         WIDTH_32: r = sgn ? {{32{x[31]}}, x[31:0]} : {32'b0, x[31:0]};
         default:  r = x;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] width_mask(input logic [1:0] wsel);
      logic [63:0] r;
      unique case (wsel)
         WIDTH_8:  r = 64'h0000_0000_0000_00ff;
         WIDTH_16: r = 64'h0000_0000_0000_ffff;
         WIDTH_32: r = 64'h0000_0000_ffff_ffff;
         default:  r = 64'hffff_ffff_ffff_ffff;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] sign_bit(input logic [1:0] wsel);
      logic [63:0] r;
      unique case (wsel)
         WIDTH_8:  r = 64'h0000_0000_0000_0080;
         WIDTH_16: r = 64'h0000_0000_0000_8000;
         WIDTH_32: r = 64'h0000_0000_8000_0000;
         default:  r = 64'h8000_0000_0000_0000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cia_req_if.sv =====
`default_nettype none
interface cia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [1:0]  width_sel;
   logic        is_signed;
   logic [63:0] left_operand;
   logic [63:0] right_operand;

   modport source (output valid, func, width_sel, is_signed, left_operand, right_operand,
                   input ready);
   modport sink (input valid, func, width_sel, is_signed, left_operand, right_operand,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cia_rsp_if.sv =====
`default_nettype none
interface cia_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [2:0]  error_code;

   modport source (output valid, value, error_code, input ready);
   modport sink (input valid, value, error_code, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/checked_integer_alu.sv =====
`default_nettype none
// Trapping add, multiply and divide on 8, 16, 32 or 64 bit operands. One transaction is
// taken every cycle while the output is not stalled, and results leave in order after
// one input stage, 64 stages of a restoring divider that retire one quotient bit each,
// and one output stage. Add and multiply ride the same pipeline, the multiply being
// formed from four 32 by 32 partial products over two of those stages. The whole
// pipeline holds while a result waits at the output and the output is not taken.
module checked_integer_alu (
   input  wire logic clock,
   input  wire logic reset,
   cia_req_if.sink   req,
   cia_rsp_if.source rsp
);
   localparam int N = cia_pkg::DIV_STEPS;

   logic               adv;
   cia_pkg::stage_type stage_w [0:N];
   logic [63:0]        mul_hi, mul_lo;

   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   cia_prep u_prep (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req.valid),
      .func(req.func), .width_sel(req.width_sel), .is_signed(req.is_signed),
      .left_operand(req.left_operand), .right_operand(req.right_operand),
      .st_ff(stage_w[0])
   );

   cia_mul u_mul (
      .clock(clock), .en(adv), .mul_a(stage_w[0].quo), .mul_b(stage_w[0].divisor),
      .hi_ff(mul_hi), .lo_ff(mul_lo)
   );

   genvar k;
   for (k = 0; k < N; k++) begin : g_step
      cia_pkg::stage_type step_in;
      if (k == 2) begin : g_mul
         always_comb begin
            step_in = stage_w[k];
            step_in.mhi = mul_hi;
            step_in.mlo = mul_lo;
         end
      end else begin : g_pass
         assign step_in = stage_w[k];
      end
      cia_div_step u_step (
         .clock(clock), .reset(reset), .en(adv), .st_in(step_in), .st_ff(stage_w[k+1])
      );
   end

   cia_finish u_finish (
      .clock(clock), .reset(reset), .en(adv), .st_in(stage_w[N]),
      .valid_ff(rsp.valid), .value_ff(rsp.value), .error_ff(rsp.error_code)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/cia_prep.sv =====
`default_nettype none
module cia_prep (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [1:0]          func,
   input  wire logic [1:0]          width_sel,
   input  wire logic                is_signed,
   input  wire logic [63:0]         left_operand,
   input  wire logic [63:0]         right_operand,
   output cia_pkg::stage_type       st_ff
);
   cia_pkg::stage_type st_in;
   logic [63:0]        a_ext;
   logic [63:0]        b_ext;

   always_comb begin
      a_ext = cia_pkg::ext_value(left_operand, width_sel, is_signed);
      b_ext = cia_pkg::ext_value(right_operand, width_sel, is_signed);
      st_in.valid = in_valid;
      st_in.func = func;
      st_in.wsel = width_sel;
      st_in.sgn = is_signed;
      st_in.a = a_ext;
      st_in.b = b_ext;
      st_in.quo = (is_signed && a_ext[63]) ? (64'd0 - a_ext) : a_ext;
      st_in.divisor = (is_signed && b_ext[63]) ? (64'd0 - b_ext) : b_ext;
      st_in.rem = 64'd0;
      st_in.mhi = 64'd0;
      st_in.mlo = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cia_mul.sv =====
`default_nettype none
module cia_mul (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] mul_a,
   input  wire logic [63:0] mul_b,
   output logic [63:0]      hi_ff,
   output logic [63:0]      lo_ff
);
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0] mid;
   logic [63:0] hi_in, lo_in;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= mul_a[31:0] * mul_b[31:0];
         lh_ff <= mul_a[31:0] * mul_b[63:32];
         hl_ff <= mul_a[63:32] * mul_b[31:0];
         hh_ff <= mul_a[63:32] * mul_b[63:32];
      end
   end

   always_comb begin
      mid = {32'b0, ll_ff[63:32]} + {32'b0, lh_ff[31:0]} + {32'b0, hl_ff[31:0]};
      lo_in = {mid[31:0], ll_ff[31:0]};
      hi_in = hh_ff + {32'b0, lh_ff[63:32]} + {32'b0, hl_ff[63:32]} + {32'b0, mid[63:32]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cia_div_step.sv =====
`default_nettype none
module cia_div_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire cia_pkg::stage_type  st_in,
   output cia_pkg::stage_type       st_ff
);
   cia_pkg::stage_type st_next;
   logic [64:0]        trial;
   logic [64:0]        diff;

   always_comb begin
      st_next = st_in;
      trial = {st_in.rem, st_in.quo[63]};
      diff = trial - {1'b0, st_in.divisor};
      if (trial >= {1'b0, st_in.divisor}) begin
         st_next.rem = diff[63:0];
         st_next.quo = {st_in.quo[62:0], 1'b1};
      end else begin
         st_next.rem = trial[63:0];
         st_next.quo = {st_in.quo[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_next;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cia_finish.sv =====
`default_nettype none
module cia_finish (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire cia_pkg::stage_type  st_in,
   output logic                     valid_ff,
   output logic [63:0]              value_ff,
   output logic [2:0]               error_ff
);
   logic [63:0] mask, sb, minv, sum, prod, quot;
   logic        diff_sign, mul_neg, add_ovf, mul_ovf;
   logic [63:0] value_in;
   logic [2:0]  error_in;

   always_comb begin
      mask = cia_pkg::width_mask(st_in.wsel);
      sb = cia_pkg::sign_bit(st_in.wsel);
      minv = cia_pkg::ext_value(sb, st_in.wsel, 1'b1);
      diff_sign = st_in.sgn && (st_in.a[63] ^ st_in.b[63]);
      sum = (st_in.a + st_in.b) & mask;
      if (st_in.sgn) begin
         add_ovf = (((st_in.a ^ sum) & (st_in.b ^ sum) & sb) != 64'd0);
      end else begin
         add_ovf = sum < (st_in.a & mask);
      end
      prod = diff_sign ? (64'd0 - st_in.mlo) : st_in.mlo;
      mul_neg = diff_sign && (st_in.a != 64'd0) && (st_in.b != 64'd0);
      if (st_in.sgn) begin
         mul_ovf = (st_in.mhi != 64'd0) || (mul_neg ? (st_in.mlo > sb) : (st_in.mlo >= sb));
      end else begin
         mul_ovf = (st_in.mhi != 64'd0) || ((st_in.mlo & ~mask) != 64'd0);
      end
      quot = diff_sign ? (64'd0 - st_in.quo) : st_in.quo;
      value_in = 64'd0;
      error_in = cia_pkg::ERR_OK;
      unique case (st_in.func)
         cia_pkg::FUNC_ADD: begin
            value_in = cia_pkg::ext_value(sum, st_in.wsel, st_in.sgn);
            error_in = add_ovf ? cia_pkg::ERR_ADD_OVF : cia_pkg::ERR_OK;
         end
         cia_pkg::FUNC_MUL: begin
            value_in = cia_pkg::ext_value(prod, st_in.wsel, st_in.sgn);
            error_in = mul_ovf ? cia_pkg::ERR_MUL_OVF : cia_pkg::ERR_OK;
         end
         cia_pkg::FUNC_DIV: begin
            priority if ((st_in.b & mask) == 64'd0) begin
               error_in = cia_pkg::ERR_DIV_ZERO;
            end else if (st_in.sgn && st_in.a == minv && st_in.b == 64'hffff_ffff_ffff_ffff)
            begin
               error_in = cia_pkg::ERR_DIV_OVF;
               value_in = minv;
            end else begin
               value_in = cia_pkg::ext_value(quot, st_in.wsel, st_in.sgn);
            end
         end
         default: begin
            value_in = 64'd0;
            error_in = cia_pkg::ERR_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= st_in.valid;
         value_ff <= value_in;
         error_ff <= error_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cia_checker.sv =====
`default_nettype none
module cia_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_value,
   input wire logic [2:0]  rsp_error_code
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_error_code))
      else $error("stalled result changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= cia_pkg::ERR_DIV_OVF)
      else $error("bad error code");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == cia_pkg::ERR_DIV_ZERO |-> rsp_value == 64'd0)
      else $error("divide by zero value not zero");

   a_flow: assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("input stalled while output drains");
endmodule

bind checked_integer_alu cia_checker u_cia_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_value(rsp.value), .rsp_error_code(rsp.error_code)
);
`default_nettype wire
